// File: design/countdown_timer_bank_macros.svh
// Assertion macros for the countdown timer bank.
// No dependencies; included by the top level.
`ifndef COUNTDOWN_TIMER_BANK_MACROS_SVH
`define COUNTDOWN_TIMER_BANK_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CTB_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (c)) \
    else $error("countdown_timer_bank: check failed");
`define CTB_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (c)) \
    else $error("countdown_timer_bank: check failed");
`else
`define CTB_ASSERT_IMP(lbl, a, c)
`define CTB_ASSERT_NXT(lbl, a, c)
`endif
`endif

// File: design/ctb_pkg.sv
// Shared types, codes and constants of the countdown timer bank.
// No dependencies.
package ctb_pkg;

  localparam int unsigned SLOTS_DEF = 16;
  localparam int unsigned MAX_ROWS  = 16;

  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_ADD     = 3'd1;
  localparam logic [2:0] CMD_CANCEL  = 3'd2;
  localparam logic [2:0] CMD_DISMISS = 3'd3;
  localparam logic [2:0] CMD_LIST    = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_BUSY    = 2'd2;

  localparam logic [3:0] REG_GRACE = 4'd0;
  localparam logic [3:0] REG_RING  = 4'd1;

  localparam logic [19:0] MAX_SECONDS = 20'd604800;
  localparam logic [9:0]  MS_PER_S    = 10'd1000;
  // ahead times at or above this saturate the seconds field
  localparam logic [47:0] SAT_MS      = 48'd604801000;
  // ceil(2^40 / 1000), exact quotient for dividends below 2^30
  localparam logic [30:0] RECIP_1000  = 31'd1099511628;

  localparam int unsigned IN_W  = 104;
  localparam int unsigned OUT_W = 136;

  typedef struct packed {
    logic [31:0] id;
    logic        ring;
    logic [19:0] secs;
    logic [47:0] due;
  } entry_t;

  function automatic logic [OUT_W-1:0] pack_row(
    logic [1:0] status, logic [31:0] aid, logic [4:0] stopped, logic valid,
    logic [31:0] eid, logic ering, logic [19:0] esec, logic [31:0] missed,
    logic [4:0] rcnt);
    pack_row = {6'd0, rcnt, missed, esec, ering, eid, valid, stopped, aid, status};
  endfunction

endpackage

// File: design/ctb_mem.sv
// Entry store: one write port, one registered read port.
// Depends on ctb_pkg.
module ctb_mem #(
  parameter int unsigned SLOTS = ctb_pkg::SLOTS_DEF,
  parameter int unsigned IW    = 4
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IW-1:0]   waddr_i,
  input  ctb_pkg::entry_t wdata_i,
  input  logic            re_i,
  input  logic [IW-1:0]   raddr_i,
  output ctb_pkg::entry_t rdata_o
);
  ctb_pkg::entry_t mem [SLOTS];
  ctb_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// File: design/ctb_sec_div.sv
// Whole seconds from a millisecond span below 2^30, by reciprocal multiply.
// Depends on ctb_pkg.
module ctb_sec_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [29:0] ms_i,
  output logic [19:0] secs_o
);
  logic [60:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= 61'(ms_i) * 61'(ctb_pkg::RECIP_1000);
    end
  end

  assign secs_o = prod_q[59:40];
endmodule

// File: design/countdown_timer_bank.sv
// Countdown timer bank: ordered timers kept in a single entry memory.
// Depends on ctb_pkg, ctb_mem, ctb_sec_div and countdown_timer_bank_macros.svh.
//
// Input items arrive on s_axis (tuser = command, tdata = now_ms, duration_s,
// timer_id). Results leave on m_axis, one or more per item, tlast on the
// final one. Registers are written on the cfg channel, always ready.
// One item is in work at a time; s_axis_tready_o is high only when idle.
// Work from accept to result loaded, by command:
//   add: one write, then the result. invalid add, busy add, unknown command: result only.
//   tick, dismiss: one pass over the entries (walk, read, evaluate,
//   reciprocal multiply, write back per entry through the memory port).
//   cancel: two passes, a tick and then the search.  list: one tick pass, then
//   one row per entry (a single row on an empty bank).
// A result register parts the sides: a new item is taken while a result
// waits, and the walk halts only when a further result must be loaded.
// Reset empties the bank, sets the next id to 1, clears the missed count
// and loads 60 s into both registers; the memory itself is not cleared.
`include "countdown_timer_bank_macros.svh"
module countdown_timer_bank #(
  parameter int unsigned SLOTS = ctb_pkg::SLOTS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // now_ms[47:0], duration_s[67:48], timer_id[99:68], zero pad
  input  logic [ctb_pkg::IN_W-1:0]  s_axis_tdata_i,
  // cmd[2:0]
  input  logic [2:0]                s_axis_tuser_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // status[1:0], assigned_id[33:2], stopped_count[38:34], entry_valid[39],
  // entry_id[71:40], entry_ringing[72], entry_seconds_remaining[92:73],
  // missed_count[124:93], ringing_count[129:125], zero pad
  output logic [ctb_pkg::OUT_W-1:0] m_axis_tdata_o,
  output logic                      m_axis_tlast_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [3:0]                cfg_index_i,
  input  logic [11:0]               cfg_data_i
);
  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ADD  = 4'd1;
  localparam logic [3:0] S_WALK = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_EV   = 4'd4;
  localparam logic [3:0] S_MUL  = 4'd5;
  localparam logic [3:0] S_WR   = 4'd6;
  localparam logic [3:0] S_LST  = 4'd7;
  localparam logic [3:0] S_LRD  = 4'd8;
  localparam logic [3:0] S_LOUT = 4'd9;
  localparam logic [3:0] S_EMIT = 4'd10;

  localparam logic [1:0] WK_TICK = 2'd0;
  localparam logic [1:0] WK_CAN  = 2'd1;
  localparam logic [1:0] WK_DIS  = 2'd2;

  logic [3:0]    state_q;
  logic [1:0]    mode_q;
  logic [2:0]    cmd_q;
  logic [47:0]   now_q;
  logic [31:0]   tid_q;
  logic [19:0]   dur_q;
  logic [29:0]   dur_ms_q;
  logic [CW-1:0] active_q, r_q, w_q, acc_q, ring_q, stopped_q;
  logic [4:0]    rows_q;
  logic [31:0]   next_id_q, missed_q, aid_q;
  logic [21:0]   grace_ms_q, ring_ms_q;
  logic [1:0]    stat_q;
  logic          found_q, keep_q, div_q;
  logic [29:0]   diff_q;
  ctb_pkg::entry_t ent_q;

  logic            out_valid_q, out_last_q;
  logic [ctb_pkg::OUT_W-1:0] out_data_q;
  logic            out_free;

  logic            mem_we, mem_re;
  logic [IW-1:0]   mem_waddr, mem_raddr;
  ctb_pkg::entry_t mem_wdata, rd;
  logic [19:0]     div_secs;

  logic            ge;
  logic [47:0]     late, ahead;
  logic [48:0]     ring_sum, add_sum;
  logic [47:0]     ring_due, add_due;
  logic            lst_last;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

  assign ge       = now_q >= rd.due;
  assign late     = now_q - rd.due;
  assign ahead    = rd.due - now_q;
  assign ring_sum = {1'b0, now_q} + 49'(ring_ms_q);
  assign ring_due = ring_sum[48] ? '1 : ring_sum[47:0];
  assign add_sum  = {1'b0, now_q} + 49'(dur_ms_q);
  assign add_due  = add_sum[48] ? '1 : add_sum[47:0];
  assign lst_last = (r_q + CW'(1) == active_q) || (rows_q == 5'(ctb_pkg::MAX_ROWS - 1));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = w_q[IW-1:0];
    mem_wdata = ent_q;
    if (div_q) begin
      mem_wdata.secs = div_secs;
    end
    if (state_q == S_ADD) begin
      mem_we         = 1'b1;
      mem_waddr      = active_q[IW-1:0];
      mem_wdata.id   = next_id_q;
      mem_wdata.ring = 1'b0;
      mem_wdata.secs = dur_q;
      mem_wdata.due  = add_due;
    end else if (state_q == S_WR) begin
      mem_we = keep_q;
    end
  end

  assign mem_re    = (state_q == S_RD) || (state_q == S_LRD);
  assign mem_raddr = r_q[IW-1:0];

  ctb_mem #(.SLOTS(SLOTS), .IW(IW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rd)
  );

  ctb_sec_div u_div (
    .clk_i  (clk_i),
    .en_i   (state_q == S_MUL),
    .ms_i   (diff_q),
    .secs_o (div_secs)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= '0;
      next_id_q   <= 32'd1;
      missed_q    <= '0;
      ring_q      <= '0;
      grace_ms_q  <= 22'd60000;
      ring_ms_q   <= 22'd60000;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == ctb_pkg::REG_GRACE) begin
          grace_ms_q <= 22'(cfg_data_i) * 22'(ctb_pkg::MS_PER_S);
        end else if (cfg_index_i == ctb_pkg::REG_RING) begin
          ring_ms_q <= 22'(cfg_data_i) * 22'(ctb_pkg::MS_PER_S);
        end
      end
      if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            cmd_q     <= s_axis_tuser_i;
            now_q     <= s_axis_tdata_i[47:0];
            tid_q     <= s_axis_tdata_i[99:68];
            dur_q     <= s_axis_tdata_i[67:48];
            dur_ms_q  <= 30'(s_axis_tdata_i[67:48]) * 30'(ctb_pkg::MS_PER_S);
            aid_q     <= '0;
            stopped_q <= '0;
            stat_q    <= ctb_pkg::ST_OK;
            r_q       <= '0;
            w_q       <= '0;
            acc_q     <= '0;
            found_q   <= 1'b0;
            mode_q    <= WK_TICK;
            state_q   <= S_WALK;
            unique case (s_axis_tuser_i) inside
              ctb_pkg::CMD_TICK, ctb_pkg::CMD_LIST: begin
              end
              ctb_pkg::CMD_CANCEL: begin
                stat_q <= ctb_pkg::ST_INVALID;
              end
              ctb_pkg::CMD_DISMISS: begin
                mode_q <= WK_DIS;
              end
              ctb_pkg::CMD_ADD: begin
                if (s_axis_tdata_i[67:48] == 20'd0 ||
                    s_axis_tdata_i[67:48] > ctb_pkg::MAX_SECONDS) begin
                  stat_q  <= ctb_pkg::ST_INVALID;
                  state_q <= S_EMIT;
                end else if (active_q >= CW'(SLOTS)) begin
                  stat_q  <= ctb_pkg::ST_BUSY;
                  state_q <= S_EMIT;
                end else begin
                  state_q <= S_ADD;
                end
              end
              default: begin
                stat_q  <= ctb_pkg::ST_INVALID;
                state_q <= S_EMIT;
              end
            endcase
          end
        end
        S_ADD: begin
          aid_q     <= next_id_q;
          next_id_q <= next_id_q + 32'd1;
          active_q  <= active_q + CW'(1);
          state_q   <= S_EMIT;
        end
        S_WALK: begin
          if (r_q == active_q) begin
            active_q <= w_q;
            ring_q   <= acc_q;
            r_q      <= '0;
            w_q      <= '0;
            acc_q    <= '0;
            if (mode_q == WK_TICK && cmd_q == ctb_pkg::CMD_CANCEL) begin
              mode_q  <= WK_CAN;
              state_q <= S_WALK;
            end else if (mode_q == WK_TICK && cmd_q == ctb_pkg::CMD_LIST) begin
              rows_q  <= '0;
              state_q <= S_LST;
            end else begin
              state_q <= S_EMIT;
            end
          end else begin
            state_q <= S_RD;
          end
        end
        S_RD: begin
          state_q <= S_EV;
        end
        S_EV: begin
          ent_q   <= rd;
          keep_q  <= 1'b1;
          div_q   <= 1'b0;
          diff_q  <= ahead[29:0];
          state_q <= S_MUL;
          case (mode_q)
            WK_TICK: begin
              if (rd.ring) begin
                keep_q <= !ge;
              end else if (ge) begin
                if (late > 48'(grace_ms_q)) begin
                  keep_q   <= 1'b0;
                  missed_q <= missed_q + 32'd1;
                end else begin
                  ent_q.ring <= 1'b1;
                  ent_q.secs <= '0;
                  ent_q.due  <= ring_due;
                end
              end else if (ahead < ctb_pkg::SAT_MS) begin
                div_q <= 1'b1;
              end else begin
                ent_q.secs <= ctb_pkg::MAX_SECONDS;
              end
            end
            WK_CAN: begin
              if (!found_q && rd.id == tid_q) begin
                found_q <= 1'b1;
                if (!rd.ring) begin
                  keep_q <= 1'b0;
                  stat_q <= ctb_pkg::ST_OK;
                end
              end
            end
            default: begin
              if (rd.ring) begin
                keep_q    <= 1'b0;
                stopped_q <= stopped_q + CW'(1);
              end
            end
          endcase
        end
        S_MUL: begin
          state_q <= S_WR;
        end
        S_WR: begin
          if (keep_q) begin
            w_q <= w_q + CW'(1);
            if (ent_q.ring) begin
              acc_q <= acc_q + CW'(1);
            end
          end
          r_q     <= r_q + CW'(1);
          state_q <= S_WALK;
        end
        S_LST: begin
          state_q <= (active_q == '0) ? S_EMIT : S_LRD;
        end
        S_LRD: begin
          state_q <= S_LOUT;
        end
        S_LOUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_last_q  <= lst_last;
            out_data_q  <= ctb_pkg::pack_row(ctb_pkg::ST_OK, '0, '0, 1'b1, rd.id,
                             rd.ring, rd.ring ? 20'd0 : rd.secs, missed_q, 5'(ring_q));
            r_q     <= r_q + CW'(1);
            rows_q  <= rows_q + 5'd1;
            state_q <= lst_last ? S_IDLE : S_LRD;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_last_q  <= 1'b1;
            out_data_q  <= ctb_pkg::pack_row(stat_q, aid_q, 5'(stopped_q), 1'b0, '0,
                             1'b0, '0, missed_q, 5'(ring_q));
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `CTB_ASSERT_IMP(a_active_bound, 1'b1, active_q <= CW'(SLOTS))
  `CTB_ASSERT_IMP(a_ring_bound, state_q == S_IDLE, ring_q <= active_q)
  `CTB_ASSERT_IMP(a_compact_order, state_q == S_WR, w_q <= r_q)
  `CTB_ASSERT_NXT(a_accept_busy, s_axis_tvalid_i && s_axis_tready_o, state_q != S_IDLE)
endmodule

// File: dv/testbench.sv
// Self-checking testbench for countdown_timer_bank: clocked stream driver and monitor,
// an in-bench predictor of the timer bank and per-field result checks.
// Depends on ctb_pkg and the RTL of countdown_timer_bank.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [2:0]  cmd;
    logic [47:0] now;
    logic [19:0] dur;
    logic [31:0] id;
  } cmd_item_t;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] aid;
    logic [4:0]  stopped;
    logic        valid;
    logic [31:0] eid;
    logic        ering;
    logic [19:0] esec;
    logic [31:0] missed;
    logic [4:0]  rcnt;
    logic        last;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_valid = 1'b0;
  logic s_tready;
  logic [ctb_pkg::IN_W-1:0] s_tdata = '0;
  logic [2:0] s_tuser = ctb_pkg::CMD_TICK;
  logic m_tvalid;
  logic m_ready = 1'b0;
  logic [ctb_pkg::OUT_W-1:0] m_tdata;
  logic m_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_index = ctb_pkg::REG_GRACE;
  logic [11:0] cfg_data = '0;

  cmd_item_t pending_q[$];
  cmd_item_t cur_item;
  row_t rows_q[$];
  int errors = 0;
  int hold_left = 0;
  int idle_pct = 81;
  bit tx_idle = 0;
  bit rx_stall = 0;

  // bank mirror
  ctb_pkg::entry_t bank[16];
  int n_act = 0;
  logic [31:0] next_tid = 32'd1;
  logic [31:0] missed_tot = '0;
  logic [11:0] grace_s = 12'd60;
  logic [11:0] ring_s = 12'd60;

  countdown_timer_bank u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_tready),
    .s_axis_tdata_i(s_tdata), .s_axis_tuser_i(s_tuser),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_tdata), .m_axis_tlast_o(m_tlast),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [47:0] due_at(logic [47:0] now, logic [31:0] secs);
    longint unsigned t;
    t = longint'(now) + longint'(secs) * 1000;
    return (t > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : t[47:0];
  endfunction

  function automatic void drop_entry(int k);
    for (int j = k; j + 1 < n_act; j++) bank[j] = bank[j + 1];
    if (n_act > 0) n_act--;
  endfunction

  function automatic void tick_bank(logic [47:0] now);
    int k;
    longint unsigned s;
    k = 0;
    while (k < n_act) begin
      if (bank[k].ring) begin
        if (now >= bank[k].due) begin
          drop_entry(k);
          continue;
        end
      end else if (now >= bank[k].due) begin
        if (longint'(now - bank[k].due) > longint'(grace_s) * 1000) begin
          drop_entry(k);
          missed_tot++;
          continue;
        end
        bank[k].ring = 1'b1;
        bank[k].secs = '0;
        bank[k].due = due_at(now, 32'(ring_s));
      end else begin
        s = longint'(bank[k].due - now) / 1000;
        bank[k].secs = (s > ctb_pkg::MAX_SECONDS) ? ctb_pkg::MAX_SECONDS : s[19:0];
      end
      k++;
    end
  endfunction

  function automatic void push_row(logic [1:0] st, logic [31:0] aid, logic [4:0] stopped,
                                   logic v, logic [31:0] eid, logic er, logic [19:0] es);
    row_t r;
    r.status = st; r.aid = aid; r.stopped = stopped; r.valid = v;
    r.eid = eid; r.ering = er; r.esec = es; r.missed = missed_tot;
    r.rcnt = '0;
    for (int k = 0; k < n_act; k++) if (bank[k].ring) r.rcnt++;
    r.last = 1'b0;
    rows_q.push_back(r);
  endfunction

  function automatic void predict_item(cmd_item_t it);
    logic [1:0] st;
    int n;
    int k;
    case (it.cmd)
      ctb_pkg::CMD_TICK: begin
        tick_bank(it.now);
        push_row(ctb_pkg::ST_OK, '0, '0, 1'b0, '0, 1'b0, '0);
      end
      ctb_pkg::CMD_ADD: begin
        if (it.dur < 20'd1 || it.dur > ctb_pkg::MAX_SECONDS)
          push_row(ctb_pkg::ST_INVALID, '0, '0, 1'b0, '0, 1'b0, '0);
        else if (n_act >= 16) push_row(ctb_pkg::ST_BUSY, '0, '0, 1'b0, '0, 1'b0, '0);
        else begin
          bank[n_act].id = next_tid;
          bank[n_act].ring = 1'b0;
          bank[n_act].secs = it.dur;
          bank[n_act].due = due_at(it.now, 32'(it.dur));
          n_act++;
          push_row(ctb_pkg::ST_OK, next_tid, '0, 1'b0, '0, 1'b0, '0);
          next_tid++;
        end
      end
      ctb_pkg::CMD_CANCEL: begin
        st = ctb_pkg::ST_INVALID;
        tick_bank(it.now);
        for (int j = 0; j < n_act; j++) begin
          if (bank[j].id == it.id) begin
            if (!bank[j].ring) begin
              drop_entry(j);
              st = ctb_pkg::ST_OK;
            end
            break;
          end
        end
        push_row(st, '0, '0, 1'b0, '0, 1'b0, '0);
      end
      ctb_pkg::CMD_DISMISS: begin
        n = 0;
        k = 0;
        while (k < n_act) begin
          if (bank[k].ring) begin
            drop_entry(k);
            n++;
          end else k++;
        end
        push_row(ctb_pkg::ST_OK, '0, n[4:0], 1'b0, '0, 1'b0, '0);
      end
      ctb_pkg::CMD_LIST: begin
        tick_bank(it.now);
        if (n_act == 0) push_row(ctb_pkg::ST_OK, '0, '0, 1'b0, '0, 1'b0, '0);
        for (int j = 0; j < n_act; j++)
          push_row(ctb_pkg::ST_OK, '0, '0, 1'b1, bank[j].id, bank[j].ring,
                   bank[j].ring ? 20'd0 : bank[j].secs);
      end
      default: push_row(ctb_pkg::ST_INVALID, '0, '0, 1'b0, '0, 1'b0, '0);
    endcase
    rows_q[rows_q.size() - 1].last = 1'b1;
  endfunction

  // sender
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else begin
      if (s_valid && s_tready) predict_item(cur_item);
      if (!(s_valid && !s_tready)) begin
        if (pending_q.size() > 0 && !(tx_idle && $urandom_range(99) < idle_pct)) begin
          cur_item = pending_q.pop_front();
          s_valid <= 1'b1;
          s_tuser <= cur_item.cmd;
          s_tdata <= {4'd0, cur_item.id, cur_item.dur, cur_item.now};
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, longint unsigned e, longint unsigned a);
    if (e != a) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, e, a);
      errors++;
    end
  endtask

  // receiver
  always @(posedge clk_i) begin
    row_t e;
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_tvalid && m_ready) begin
        if (rows_q.size() == 0) begin
          $error("unexpected result item");
          errors++;
        end else begin
          e = rows_q.pop_front();
          check_field("status", e.status, m_tdata[1:0]);
          check_field("assigned_id", e.aid, m_tdata[33:2]);
          check_field("stopped_count", e.stopped, m_tdata[38:34]);
          check_field("entry_valid", e.valid, m_tdata[39]);
          check_field("entry_id", e.eid, m_tdata[71:40]);
          check_field("entry_ringing", e.ering, m_tdata[72]);
          check_field("entry_seconds_remaining", e.esec, m_tdata[92:73]);
          check_field("missed_count", e.missed, m_tdata[124:93]);
          check_field("ringing_count", e.rcnt, m_tdata[129:125]);
          check_field("last", e.last, m_tlast);
        end
      end
      m_ready <= (hold_left > 0) ? 1'b0 :
                 (rx_stall ? ($urandom_range(99) >= idle_pct) : 1'b1);
    end
  end

  always @(posedge clk_i) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

  logic [47:0] t_now = '0;
  logic [31:0] guess_id = 32'd1;

  function automatic void add_item(logic [2:0] c, logic [47:0] now, logic [19:0] d,
                                   logic [31:0] id);
    cmd_item_t it;
    it.cmd = c; it.now = now; it.dur = d; it.id = id;
    pending_q.push_back(it);
  endfunction

  function automatic void rand_item();
    int r;
    logic [19:0] d;
    logic [31:0] id;
    r = $urandom_range(99);
    if (r < 70) t_now += 48'($urandom_range(3000));
    else if (r < 96) t_now += 48'($urandom_range(70000));
    else t_now -= 48'($urandom_range(5000));
    r = $urandom_range(99);
    d = ($urandom_range(9) < 8) ? 20'($urandom_range(1, 40)) :
        ($urandom_range(1) ? 20'($urandom_range(1, 604800)) : 20'($urandom));
    id = ($urandom_range(9) < 8) ? guess_id - 32'($urandom_range(1, 6)) : $urandom;
    if (r < 25) add_item(ctb_pkg::CMD_TICK, t_now, 20'($urandom), $urandom);
    else if (r < 55) begin
      add_item(ctb_pkg::CMD_ADD, t_now, d, $urandom);
      if (d >= 20'd1 && d <= ctb_pkg::MAX_SECONDS) guess_id++;
    end
    else if (r < 70) add_item(ctb_pkg::CMD_CANCEL, t_now, 20'($urandom), id);
    else if (r < 78) add_item(ctb_pkg::CMD_DISMISS, t_now, 20'($urandom), $urandom);
    else if (r < 95) add_item(ctb_pkg::CMD_LIST, t_now, 20'($urandom), $urandom);
    else add_item(3'($urandom_range(5, 7)), t_now, 20'($urandom), $urandom);
  endfunction

  task automatic drain();
    while (pending_q.size() > 0 || s_valid || rows_q.size() > 0) @(negedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [11:0] grace, logic [11:0] ring);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= ctb_pkg::REG_GRACE;
    cfg_data <= grace;
    do @(posedge clk_i); while (!cfg_ready);
    grace_s = grace;
    cfg_index <= ctb_pkg::REG_RING;
    cfg_data <= ring;
    do @(posedge clk_i); while (!cfg_ready);
    ring_s = ring;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // directed: invalid adds, unknown commands, zero ring time, miss, overflow, backwards
    write_regs(12'd2, 12'd0);
    add_item(ctb_pkg::CMD_LIST, 48'd0, 20'd0, 32'd0);
    add_item(ctb_pkg::CMD_TICK, 48'd0, 20'd0, 32'd0);
    add_item(ctb_pkg::CMD_ADD, 48'd0, 20'd0, 32'd0);
    add_item(ctb_pkg::CMD_ADD, 48'd0, 20'd604801, 32'd0);
    add_item(ctb_pkg::CMD_ADD, 48'd0, 20'hFFFFF, 32'hFFFF_FFFF);
    add_item(ctb_pkg::CMD_ADD, 48'd0, 20'd1, 32'd0);
    add_item(ctb_pkg::CMD_ADD, 48'd0, 20'd604800, 32'd0);
    add_item(ctb_pkg::CMD_CANCEL, 48'd0, 20'd0, 32'hFFFF_FFFF);
    add_item(3'd5, 48'd0, 20'd0, 32'd0);
    add_item(3'd6, 48'd0, 20'd0, 32'd0);
    add_item(3'd7, 48'hFFFF_FFFF_FFFF, 20'hFFFFF, 32'hFFFF_FFFF);
    add_item(ctb_pkg::CMD_TICK, 48'd1000, 20'd0, 32'd0);
    add_item(ctb_pkg::CMD_LIST, 48'd1000, 20'd0, 32'd0);
    add_item(ctb_pkg::CMD_TICK, 48'd1000, 20'd0, 32'd0);
    add_item(ctb_pkg::CMD_ADD, 48'd1000, 20'd2, 32'd0);
    add_item(ctb_pkg::CMD_TICK, 48'd5000, 20'd0, 32'd0);
    add_item(ctb_pkg::CMD_DISMISS, 48'd5000, 20'd0, 32'd0);
    add_item(ctb_pkg::CMD_ADD, 48'd5000, 20'd1, 32'd0);
    add_item(ctb_pkg::CMD_TICK, 48'd9000, 20'd0, 32'd0);
    add_item(ctb_pkg::CMD_CANCEL, 48'd9000, 20'd0, 32'd2);
    add_item(ctb_pkg::CMD_ADD, 48'hFFFF_FFFF_FFFF, 20'd100, 32'd0);
    add_item(ctb_pkg::CMD_LIST, 48'hFFFF_FFFF_FFFF, 20'd0, 32'd0);
    add_item(ctb_pkg::CMD_LIST, 48'd0, 20'd0, 32'd0);
    add_item(ctb_pkg::CMD_DISMISS, 48'd0, 20'd0, 32'd0);
    guess_id = 32'd6;
    t_now = 48'd10000;
    drain();

    // no idling, sender pauses for a full drain midway
    write_regs(12'd3600, 12'd1);
    repeat (12) rand_item();
    drain();
    repeat (13) rand_item();
    drain();

    // sender idle; long ring time and an add burst to fill the bank
    tx_idle = 1;
    write_regs(12'd0, 12'd3600);
    repeat (18) begin
      add_item(ctb_pkg::CMD_ADD, t_now, 20'($urandom_range(1, 604800)), 32'd0);
      guess_id++;
    end
    repeat (20) rand_item();
    drain();

    // receiver stalls, with one long hold while items keep coming
    tx_idle = 0;
    rx_stall = 1;
    write_regs(12'd10, 12'd5);
    repeat (8) add_item(ctb_pkg::CMD_ADD, t_now, 20'($urandom_range(1, 30)), 32'd0);
    guess_id += 32'd8;
    repeat (25) rand_item();
    @(negedge clk_i) hold_left = 400;
    drain();

    // both sides idle
    tx_idle = 1;
    idle_pct = 29;
    write_regs(12'd4095, 12'd4095);
    repeat (25) rand_item();
    drain();

    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end
endmodule
